// ===== design/mvpe_pkg.sv =====
// ----------------------------------------------------------------------------
// mvpe_pkg: shared types and codes of the matrix-vector product engine
// Holds the input action codes, the configuration register indexes and the
// tag that travels with each matrix element down the multiply pipeline.
// ----------------------------------------------------------------------------
package mvpe_pkg;

    // Input action codes
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_MATRIX = 1'b1;

    // Configuration register indexes
    localparam logic REG_NUM_COLS = 1'b0;
    localparam logic REG_NUM_ROWS = 1'b1;

    localparam int VAL_W   = 16;
    localparam int ROW_W   = 16;
    localparam int NCOL_W  = 11;
    localparam int ACC_W   = 42;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int CFG_W   = 16;

    // Per-element control that follows the data through the pipeline
    typedef struct packed {
        logic             row_end;
        logic [ROW_W-1:0] row_index;
        logic             last_row;
    } mvpe_tag_t;

endpackage

// ===== design/mvpe_vec_mem.sv =====
// ----------------------------------------------------------------------------
// mvpe_vec_mem: vector element store
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module mvpe_vec_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [mvpe_pkg::VAL_W-1:0]  wdata,
    input  logic                        re,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [mvpe_pkg::VAL_W-1:0]  rdata
);
    import mvpe_pkg::*;

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/mvpe_seq.sv =====
// ----------------------------------------------------------------------------
// mvpe_seq: load position, column and row sequencing
// Turns each accepted item into a store write (load) or a store read plus a
// row tag (matrix element).
// ----------------------------------------------------------------------------
module mvpe_seq #(
    parameter int ADDR_W = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        take,
    input  logic                        action,
    input  logic [ADDR_W:0]             cols,
    input  logic [mvpe_pkg::ROW_W-1:0]  rows,
    output logic                        mem_we,
    output logic [ADDR_W-1:0]           mem_waddr,
    output logic                        mem_re,
    output logic [ADDR_W-1:0]           mem_raddr,
    output mvpe_pkg::mvpe_tag_t         tag
);
    import mvpe_pkg::*;

    logic [ADDR_W-1:0] load_pos_reg, load_pos_next;
    logic [ADDR_W-1:0] col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0]  row_cnt_reg, row_cnt_next;

    logic [ADDR_W-1:0] lp_cur;
    logic [ADDR_W:0]   lp_inc;
    logic [ADDR_W:0]   col_inc;
    logic [ROW_W-1:0]  rc_cur;
    logic [ROW_W:0]    rc_inc;
    logic              row_end;
    logic              last;

    always_comb
    begin
        // Wrap a position left beyond a shortened vector
        lp_cur  = ({1'b0, load_pos_reg} >= cols) ? '0 : load_pos_reg;
        lp_inc  = {1'b0, lp_cur} + 1'b1;
        col_inc = {1'b0, col_cnt_reg} + 1'b1;
        row_end = !(col_inc < cols);
        rc_cur  = (row_cnt_reg >= rows) ? '0 : row_cnt_reg;
        rc_inc  = {1'b0, rc_cur} + 1'b1;
        last    = (rc_inc >= {1'b0, rows});

        load_pos_next = load_pos_reg;
        col_cnt_next  = col_cnt_reg;
        row_cnt_next  = row_cnt_reg;

        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = lp_cur;
        mem_raddr = col_cnt_reg;

        tag.row_end   = row_end;
        tag.row_index = rc_cur;
        tag.last_row  = last;

        if (take)
        begin
            case (action)
                ACT_LOAD:
                begin
                    mem_we        = 1'b1;
                    load_pos_next = (lp_inc >= cols) ? '0 : lp_inc[ADDR_W-1:0];
                end
                ACT_MATRIX:
                begin
                    mem_re = 1'b1;
                    if (row_end)
                    begin
                        col_cnt_next = '0;
                        row_cnt_next = last ? '0 : rc_inc[ROW_W-1:0];
                    end
                    else
                    begin
                        col_cnt_next = col_inc[ADDR_W-1:0];
                    end
                end
                default:
                begin
                    mem_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_pos_reg <= '0;
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
        end
        else
        begin
            load_pos_reg <= load_pos_next;
            col_cnt_reg  <= col_cnt_next;
            row_cnt_reg  <= row_cnt_next;
        end
    end

endmodule

// ===== design/mvpe_mac.sv =====
// ----------------------------------------------------------------------------
// mvpe_mac: multiply-accumulate pipeline and result register
// Stage 1 waits for store data, stage 2 holds the product, then the row
// accumulator adds it and hands finished rows to the output register.
// ----------------------------------------------------------------------------
module mvpe_mac (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_take,
    input  logic signed [mvpe_pkg::VAL_W-1:0]  in_value,
    input  mvpe_pkg::mvpe_tag_t                in_tag,
    input  logic [mvpe_pkg::VAL_W-1:0]         vec_data,
    output logic                               s1_free,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [mvpe_pkg::ACC_W-1:0]  row_sum,
    output logic [mvpe_pkg::ROW_W-1:0]         row_index,
    output logic                               last_row
);
    import mvpe_pkg::*;

    logic                     s1_valid_reg;
    logic signed [VAL_W-1:0]  s1_val_reg;
    mvpe_tag_t                s1_tag_reg;

    logic                     s2_valid_reg;
    logic signed [PROD_W-1:0] prod_reg;
    mvpe_tag_t                s2_tag_reg;

    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         acc_sum;

    logic                     out_valid_reg;
    logic [ACC_W-1:0]         row_sum_reg;
    logic [ROW_W-1:0]         row_index_reg;
    logic                     last_row_reg;

    logic                     s2_block;
    logic                     s2_free;
    logic                     s2_fire;
    logic                     emit;

    always_comb
    begin
        // Only a row-ending element waits on a full, stalled result register
        s2_block = s2_valid_reg && s2_tag_reg.row_end && out_valid_reg && out_stall;
        s2_free  = !s2_valid_reg || !s2_block;
        s1_free  = !s1_valid_reg || s2_free;
        s2_fire  = s2_valid_reg && !s2_block;
        emit     = s2_fire && s2_tag_reg.row_end;
        acc_sum  = acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (s1_free && in_take)
        begin
            s1_val_reg <= in_value;
            s1_tag_reg <= in_tag;
        end
        if (s2_free && s1_valid_reg)
        begin
            prod_reg   <= PROD_W'(s1_val_reg) * PROD_W'($signed(vec_data));
            s2_tag_reg <= s1_tag_reg;
        end
        if (emit)
        begin
            row_sum_reg   <= acc_sum;
            row_index_reg <= s2_tag_reg.row_index;
            last_row_reg  <= s2_tag_reg.last_row;
        end
    end

    // Control and accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= in_take;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s2_fire)
            begin
                acc_reg <= s2_tag_reg.row_end ? '0 : acc_sum;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign row_sum   = row_sum_reg;
    assign row_index = row_index_reg;
    assign last_row  = last_row_reg;

endmodule

// ===== design/matrix_vector_product_engine_unit.sv =====
// ----------------------------------------------------------------------------
// matrix_vector_product_engine_unit: streaming integer matrix-vector product
//
// Input channel (in_valid / in_stall, action, element_value): action 0 loads
// the next vector element into the vector store, action 1 supplies the next
// matrix element in row-major order. One item transfers per cycle whenever
// in_stall is low; loads and matrix elements may be mixed freely.
// Output channel (out_valid / out_stall, row_sum, row_index, last_row): one
// transfer per finished row, after num_cols matrix elements.
// A row's last element passes the store read (on its transfer edge), the
// multiply and the accumulate before its result shows on out_valid.
// Throughput: one item per cycle while in_stall is low, set by the single read
// and write ports of the vector store.
// When the receiver stalls, the result register holds; items keep flowing
// until a row-ending element reaches the accumulator, then the pipeline
// fills and in_stall rises.
// Reset clears all counters, the accumulator and the pipeline; num_cols and
// num_rows return to 16. The vector store is not cleared: load a vector
// before streaming a matrix that uses it.
// Configuration: cfg_we with cfg_index 0 (num_cols) or 1 (num_rows).
// ----------------------------------------------------------------------------
module matrix_vector_product_engine_unit #(
    parameter int MAX_COLS = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               action,
    input  logic signed [mvpe_pkg::VAL_W-1:0]  element_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [mvpe_pkg::ACC_W-1:0]  row_sum,
    output logic [mvpe_pkg::ROW_W-1:0]         row_index,
    output logic                               last_row,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [mvpe_pkg::CFG_W-1:0]         cfg_data
);
    import mvpe_pkg::*;

    localparam int ADDR_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic [NCOL_W-1:0] num_cols_reg;
    logic [ROW_W-1:0]  num_rows_reg;

    logic [ADDR_W:0]   cols;
    logic [ROW_W-1:0]  rows;

    logic              s1_free;
    logic              take;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [VAL_W-1:0]  vec_data;
    mvpe_tag_t         tag;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg <= NCOL_W'(16);
            num_rows_reg <= ROW_W'(16);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NUM_COLS: num_cols_reg <= cfg_data[NCOL_W-1:0];
                REG_NUM_ROWS: num_rows_reg <= cfg_data[ROW_W-1:0];
                default:      num_rows_reg <= num_rows_reg;
            endcase
        end
    end

    // Clamp the limits in use: zero counts as one, columns saturate at the store depth
    always_comb
    begin
        if (num_cols_reg == '0)
        begin
            cols = (ADDR_W+1)'(1);
        end
        else if (32'(num_cols_reg) > 32'(MAX_COLS))
        begin
            cols = (ADDR_W+1)'(MAX_COLS);
        end
        else
        begin
            cols = (ADDR_W+1)'(num_cols_reg);
        end
        rows = (num_rows_reg == '0) ? ROW_W'(1) : num_rows_reg;
    end

    // Hold the input whenever the first pipeline stage cannot advance
    assign in_stall = !s1_free;
    assign take     = in_valid && !in_stall;

    mvpe_seq #(
        .ADDR_W (ADDR_W)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .action    (action),
        .cols      (cols),
        .rows      (rows),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .tag       (tag)
    );

    mvpe_vec_mem #(
        .DEPTH  (MAX_COLS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (element_value),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (vec_data)
    );

    mvpe_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_take   (mem_re),
        .in_value  (element_value),
        .in_tag    (tag),
        .vec_data  (vec_data),
        .s1_free   (s1_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .row_sum   (row_sum),
        .row_index (row_index),
        .last_row  (last_row)
    );

    // A finished row flagged last must be the final row of the product
    a_last_row_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_row) |-> (row_index == rows - ROW_W'(1)))
        else $error("last_row set on a row other than the final one");

    // Reported row index stays inside the product
    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (row_index < rows))
        else $error("row_index beyond num_rows");

    // One item per cycle: the store never sees a read and a write together
    a_mem_one_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("vector store read and write in the same cycle");

endmodule

// ===== dv/mvpe_row_checker.sv =====
// ----------------------------------------------------------------------------
// mvpe_row_checker: row-result predictor and comparator
// Watches the input, output and register-write ports of the matrix-vector
// product engine, keeps its own vector store and row accumulator, and
// compares every row result that transfers with the oldest predicted row.
// ----------------------------------------------------------------------------
module mvpe_row_checker #(
    parameter int MAX_COLS = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic                               action,
    input  logic signed [mvpe_pkg::VAL_W-1:0]  element_value,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic signed [mvpe_pkg::ACC_W-1:0]  row_sum,
    input  logic [mvpe_pkg::ROW_W-1:0]         row_index,
    input  logic                               last_row,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [mvpe_pkg::CFG_W-1:0]         cfg_data,
    output int                                 fail_count,
    output int                                 pending_rows,
    output int                                 rows_checked
);
    import mvpe_pkg::*;

    typedef struct packed {
        logic signed [ACC_W-1:0] sum;
        logic [ROW_W-1:0]        index;
        logic                    last;
    } row_result_t;

    logic signed [VAL_W-1:0] vec_mem [MAX_COLS];
    int unsigned             load_ptr;
    int unsigned             col_ptr;
    int unsigned             row_ptr;
    logic signed [ACC_W-1:0] row_acc;
    logic [NCOL_W-1:0]       cols_reg;
    logic [ROW_W-1:0]        rows_reg;
    row_result_t             expected_rows [$];

    // Zero columns act as one; anything past the store size saturates.
    function automatic int unsigned active_cols();
        if (cols_reg == 0)
            return 1;
        if (cols_reg > MAX_COLS)
            return MAX_COLS;
        return 32'(cols_reg);
    endfunction

    function automatic int unsigned active_rows();
        return (rows_reg == 0) ? 1 : 32'(rows_reg);
    endfunction

    task automatic accumulate_element(input logic act, input logic signed [VAL_W-1:0] val);
        int unsigned              cols;
        int unsigned              rows;
        logic signed [PROD_W-1:0] prod;
        row_result_t              res;
        cols = active_cols();
        rows = active_rows();
        if (act == ACT_LOAD)
        begin
            if (load_ptr >= cols)
                load_ptr = 0;
            vec_mem[load_ptr] = val;
            load_ptr = (load_ptr + 1 >= cols) ? 0 : load_ptr + 1;
        end
        else
        begin
            prod = '0;
            if (col_ptr < MAX_COLS)
                prod = PROD_W'(val) * PROD_W'(vec_mem[col_ptr]);
            row_acc = row_acc + ACC_W'(prod);
            if (col_ptr + 1 < cols)
            begin
                col_ptr++;
            end
            else
            begin
                // Row closes: a row counter left beyond a shrunken limit wraps first.
                col_ptr = 0;
                if (row_ptr >= rows)
                    row_ptr = 0;
                res.sum   = row_acc;
                res.index = row_ptr[ROW_W-1:0];
                res.last  = (row_ptr + 1 >= rows);
                expected_rows.push_back(res);
                row_ptr = (row_ptr + 1 >= rows) ? 0 : row_ptr + 1;
                row_acc = '0;
            end
        end
    endtask

    task automatic check_row();
        row_result_t want;
        if (expected_rows.size() == 0)
        begin
            $error("row result with none predicted: row_index %0d, row_sum %0d",
                   row_index, row_sum);
            fail_count++;
            return;
        end
        want = expected_rows.pop_front();
        rows_checked++;
        if (row_sum !== want.sum)
        begin
            $error("row_sum: expected %0d, actual %0d", want.sum, row_sum);
            fail_count++;
        end
        if (row_index !== want.index)
        begin
            $error("row_index: expected %0d, actual %0d", want.index, row_index);
            fail_count++;
        end
        if (last_row !== want.last)
        begin
            $error("last_row: expected %0b, actual %0b", want.last, last_row);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_ptr     = 0;
            col_ptr      = 0;
            row_ptr      = 0;
            row_acc      = '0;
            cols_reg     = NCOL_W'(16);
            rows_reg     = ROW_W'(16);
            fail_count   = 0;
            rows_checked = 0;
            expected_rows.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_NUM_COLS)
                    cols_reg = cfg_data[NCOL_W-1:0];
                else
                    rows_reg = cfg_data[ROW_W-1:0];
            end
            if (in_valid && !in_stall)
                accumulate_element(action, element_value);
            if (out_valid && !out_stall)
                check_row();
        end
        pending_rows = expected_rows.size();
    end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the matrix-vector product engine
// Streams vector loads and matrix elements through the input channel under
// random idling and output back-pressure, across many num_cols / num_rows
// settings, and leaves the row-by-row prediction to mvpe_row_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import mvpe_pkg::*;

    localparam int MAX_COLS     = 1024;
    localparam int RANDOM_ITEMS = 1500;
    // Entries written up front so no later read finds an unwritten one
    localparam int FILL_COLS    = 64;
    // Margin for the pipeline to settle after the last predicted row.
    localparam int DRAIN_CYCLES = 8;
    // Hard cap on simulated cycles, far above what a legal run needs.
    localparam int CYCLE_LIMIT  = 1_000_000;

    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    in_valid      = 1'b0;
    logic                    action        = ACT_LOAD;
    logic signed [VAL_W-1:0] element_value = '0;
    logic                    out_stall     = 1'b0;
    logic                    cfg_we        = 1'b0;
    logic                    cfg_index     = REG_NUM_COLS;
    logic [CFG_W-1:0]        cfg_data      = '0;

    logic                    in_stall;
    logic                    out_valid;
    logic signed [ACC_W-1:0] row_sum;
    logic [ROW_W-1:0]        row_index;
    logic                    last_row;

    int fail_count;
    int pending_rows;
    int rows_checked;

    int          cycles      = 0;
    int          loads_sent  = 0;
    int          elems_sent  = 0;
    int          reg_writes  = 0;
    int          stall_left  = 0;
    bit          tx_quiet    = 1'b0;
    bit          rx_quiet    = 1'b0;
    // Column count in force, used only to shape whole rows in the stimulus
    int unsigned cols_now    = 16;

    always #4 clk = ~clk;

    matrix_vector_product_engine_unit #(
        .MAX_COLS(MAX_COLS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .element_value(element_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .row_sum      (row_sum),
        .row_index    (row_index),
        .last_row     (last_row),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    mvpe_row_checker #(
        .MAX_COLS(MAX_COLS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .element_value(element_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .row_sum      (row_sum),
        .row_index    (row_index),
        .last_row     (last_row),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending_rows (pending_rows),
        .rows_checked (rows_checked)
    );

    // Hard stop: a hung handshake or a row that never comes ends here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d rows outstanding",
                     cycles, pending_rows);
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: alternate ready stretches with stalls, mostly short, a few
    // long enough to back the pipeline up into in_stall. Hold stall low
    // while the current phase asks for a quiet receiver.
    always @(posedge clk)
    begin : rx_side
        int unsigned pick;
        if (rx_quiet)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                out_stall  <= 1'b0;
                stall_left <= $urandom_range(0, 19);
            end
            else if (pick < 85)
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end
            else if (pick < 97)
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(3, 11);
            end
            else
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(19, 39);
            end
        end
    end

    // Sender idle length before the next transfer
    function automatic int unsigned gap_len();
        int unsigned pick;
        if (tx_quiet)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 2);
        if (pick < 97)
            return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    // Element values lean on the extremes now and then
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // Present one item and hold it until it transfers.
    task automatic send_item(input logic act, input logic [VAL_W-1:0] val);
        int unsigned gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= act;
        element_value <= val;
        do @(posedge clk); while (in_stall !== 1'b0);
        if (act == ACT_LOAD)
            loads_sent++;
        else
            elems_sent++;
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
        logic [NCOL_W-1:0] ncols;
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        reg_writes++;
        if (idx == REG_NUM_COLS)
        begin
            ncols    = data[NCOL_W-1:0];
            cols_now = (ncols == 0) ? 1 : ((ncols > MAX_COLS) ? MAX_COLS : ncols);
        end
    endtask

    // Drop valid, wait for every predicted row to come back, then let any
    // trailing loads or open-row elements settle. Poll on the falling edge
    // so the checker has already booked this edge's transfers.
    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_rows != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int unsigned      sel;
        int unsigned      n;
        int               base;
        logic [CFG_W-1:0] word;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- Directed ------------------------------------------------------
        // Zero columns behave as one column, zero rows make every row the
        // last one. Upper data bits beyond the register width are ignored.
        write_reg(REG_NUM_COLS, 16'hf800);
        write_reg(REG_NUM_ROWS, 16'h0000);
        send_item(ACT_LOAD, 16'h7fff);
        send_item(ACT_MATRIX, 16'h8000);
        send_item(ACT_MATRIX, 16'h7fff);
        send_item(ACT_LOAD, 16'h8000);
        send_item(ACT_MATRIX, 16'h8000);
        drain();

        // Three columns, two rows: extreme vector, two full rows, then one
        // element of a third row left open.
        write_reg(REG_NUM_COLS, 16'd3);
        write_reg(REG_NUM_ROWS, 16'd2);
        send_item(ACT_LOAD, 16'h8000);
        send_item(ACT_LOAD, 16'h7fff);
        send_item(ACT_LOAD, 16'hffff);
        repeat (3) send_item(ACT_MATRIX, 16'h8000);
        send_item(ACT_MATRIX, 16'h7fff);
        send_item(ACT_MATRIX, 16'h0000);
        send_item(ACT_MATRIX, 16'h0001);
        send_item(ACT_MATRIX, 16'h0005);
        drain();

        // Shrink num_cols under the open row: the next element closes it,
        // still reading the column it had reached.
        write_reg(REG_NUM_COLS, 16'd1);
        send_item(ACT_MATRIX, 16'h0007);
        drain();

        // Fill every entry the random phases can reach with the most
        // negative value, then run two rows at the extremes of the sum.
        write_reg(REG_NUM_COLS, 16'(FILL_COLS));
        write_reg(REG_NUM_ROWS, 16'hffff);
        repeat (FILL_COLS) send_item(ACT_LOAD, 16'h8000);
        repeat (FILL_COLS) send_item(ACT_MATRIX, 16'h8000);
        repeat (FILL_COLS) send_item(ACT_MATRIX, 16'h7fff);
        drain();

        // ---- Random phases -------------------------------------------------
        // Each phase starts with the block drained: the sender pauses until
        // every predicted row has arrived, then the registers may change.
        // Rows left open by the previous phase carry across the change.
        base = loads_sent + elems_sent;
        while (loads_sent + elems_sent - base < RANDOM_ITEMS)
        begin
            drain();
            tx_quiet = ($urandom_range(0, 5) == 0);
            rx_quiet <= ($urandom_range(0, 5) == 0);

            if ($urandom_range(0, 2) != 0)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 8)
                    n = 0;
                else if (sel < 75)
                    n = $urandom_range(1, 8);
                else
                    n = $urandom_range(9, 48);
                word = CFG_W'($urandom);
                word[NCOL_W-1:0] = NCOL_W'(n);
                write_reg(REG_NUM_COLS, word);
            end
            if ($urandom_range(0, 2) != 0)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 10)
                    word = '0;
                else if (sel < 20)
                    word = CFG_W'(1);
                else if (sel < 85)
                    word = CFG_W'($urandom_range(2, 6));
                else if (sel < 92)
                    word = '1;
                else
                    word = CFG_W'($urandom);
                write_reg(REG_NUM_ROWS, word);
            end

            if ($urandom_range(0, 9) < 8)
            begin
                // Well-formed: maybe a fresh vector, whole rows, maybe an
                // open tail for the next phase to close.
                if ($urandom_range(0, 1) != 0)
                    repeat (cols_now) send_item(ACT_LOAD, pick_value());
                n = $urandom_range(1, 5);
                repeat (n * cols_now) send_item(ACT_MATRIX, pick_value());
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, cols_now)) send_item(ACT_MATRIX, pick_value());
            end
            else
            begin
                // Noise: loads and matrix elements interleaved at random
                repeat ($urandom_range(4, 30))
                    send_item(($urandom_range(0, 1) != 0) ? ACT_MATRIX : ACT_LOAD,
                              pick_value());
            end
        end

        // ---- Wrap-up -------------------------------------------------------
        rx_quiet <= 1'b0;
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Streamed %0d vector loads and %0d matrix elements over %0d register writes,",
                 loads_sent, elems_sent, reg_writes);
        $display("with %0d row results compared and %0d mismatches.", rows_checked, fail_count);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
